@@ rtl/core/rbi_pkg.sv @@
// Package for the bilinear resize and int8 quantize unit.
// Holds register indexes, command codes and the structs passed between modules.
// Depends on nothing.
`default_nettype none
package rbi_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_MULT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_POINT = 3'd6;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef struct packed {
      logic [9:0]  src_width;
      logic [9:0]  src_height;
      logic [10:0] out_size;
      logic [25:0] step_x;
      logic [25:0] step_y;
   } map_cfg_type;

   typedef struct packed {
      logic [23:0]        quant_mult;
      logic signed [7:0]  zero_point;
   } quant_cfg_type;

   typedef struct packed {
      logic [9:0]        res_x;
      logic [9:0]        res_y;
      logic signed [7:0] q_r;
      logic signed [7:0] q_g;
      logic signed [7:0] q_b;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/rbi_queue.sv @@
// Two-entry queue used between the front and back parts and on the result side.
// Depends on nothing.
`default_nettype none
module rbi_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/rbi_front.sv @@
// Front part: accepts requests, drops off-grid pixels, maps coordinates and
// forms the four frame store addresses. Depends on rbi_pkg.
`default_nettype none
module rbi_front #(
   parameter int MAX_W   = 512,
   parameter int MAX_H   = 512,
   parameter int MAX_OUT = 1024,
   parameter int AW      = 18,
   parameter int JOB_W   = 78 + 4 * 18
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbi_pkg::map_cfg_type cfg,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic                 req_command,
   input  wire logic                 req_first_pixel,
   input  wire logic [7:0]           req_pixel_r,
   input  wire logic [7:0]           req_pixel_g,
   input  wire logic [7:0]           req_pixel_b,
   input  wire logic [9:0]           req_out_x,
   input  wire logic [9:0]           req_out_y,
   output logic                      job_push,
   input  wire logic                 job_full,
   output logic [JOB_W-1:0]          job_data
);
   import rbi_pkg::*;

   localparam int WW = $clog2(MAX_W + 1);
   localparam int HW = $clog2(MAX_H + 1);
   localparam int XW = (MAX_W > 1) ? $clog2(MAX_W) : 1;
   localparam int YW = (MAX_H > 1) ? $clog2(MAX_H) : 1;

   typedef enum logic [1:0] {F_IDLE, F_MAP, F_ADDR, F_PUSH} front_state_type;

   front_state_type state_ff;
   logic            cmd_ff;
   logic            first_ff;
   logic [23:0]     pix_ff;
   logic [9:0]      ox_ff;
   logic [9:0]      oy_ff;
   logic [15:0]     fx_ff;
   logic [15:0]     fy_ff;
   logic [XW-1:0]   x0_ff;
   logic [XW-1:0]   x1_ff;
   logic [YW-1:0]   y0_ff;
   logic [YW-1:0]   y1_ff;
   logic [AW-1:0]   base0_ff;
   logic [AW-1:0]   base1_ff;

   logic [WW-1:0]   w_eff;
   logic [HW-1:0]   h_eff;
   logic [13:0]     os_eff;
   logic            on_grid;
   logic [36:0]     u_x;
   logic [36:0]     u_y;
   logic [36:0]     sb_x;
   logic [36:0]     sb_y;
   logic [20:0]     a_x;
   logic [20:0]     b_x;
   logic [20:0]     a_y;
   logic [20:0]     b_y;
   logic            accept;

   function automatic logic [20:0] clamp_hi(input logic [20:0] v, input logic [20:0] hi);
      return (v > hi) ? hi : v;
   endfunction

   always_comb begin
      if (cfg.src_width == 10'd0) begin
         w_eff = WW'(1);
      end else if (14'(cfg.src_width) > 14'(MAX_W)) begin
         w_eff = WW'(MAX_W);
      end else begin
         w_eff = WW'(cfg.src_width);
      end
      if (cfg.src_height == 10'd0) begin
         h_eff = HW'(1);
      end else if (14'(cfg.src_height) > 14'(MAX_H)) begin
         h_eff = HW'(MAX_H);
      end else begin
         h_eff = HW'(cfg.src_height);
      end
      os_eff = (14'(cfg.out_size) > 14'(MAX_OUT)) ? 14'(MAX_OUT) : 14'(cfg.out_size);
   end

   assign on_grid = (14'(req_out_x) < os_eff) && (14'(req_out_y) < os_eff);
   assign u_x     = 37'({ox_ff, 1'b1}) * 37'(cfg.step_x);
   assign u_y     = 37'({oy_ff, 1'b1}) * 37'(cfg.step_y);
   assign sb_x    = {1'b0, u_x[36:1]} + 37'd32768;
   assign sb_y    = {1'b0, u_y[36:1]} + 37'd32768;
   assign a_x = (sb_x[36:16] == 21'd0) ? 21'd0
              : clamp_hi(sb_x[36:16] - 21'd1, 21'(w_eff) - 21'd1);
   assign b_x = clamp_hi(sb_x[36:16], 21'(w_eff) - 21'd1);
   assign a_y = (sb_y[36:16] == 21'd0) ? 21'd0
              : clamp_hi(sb_y[36:16] - 21'd1, 21'(h_eff) - 21'd1);
   assign b_y = clamp_hi(sb_y[36:16], 21'(h_eff) - 21'd1);

   assign req_full = (state_ff != F_IDLE);
   assign accept   = req_push && !req_full;
   assign job_push = (state_ff == F_PUSH);
   assign job_data = {cmd_ff, first_ff, pix_ff, ox_ff, oy_ff, fx_ff, fy_ff,
                      base0_ff + AW'(x0_ff), base0_ff + AW'(x1_ff),
                      base1_ff + AW'(x0_ff), base1_ff + AW'(x1_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_command;
                  first_ff <= req_first_pixel;
                  pix_ff   <= {req_pixel_b, req_pixel_g, req_pixel_r};
                  ox_ff    <= req_out_x;
                  oy_ff    <= req_out_y;
                  fx_ff    <= 16'd0;
                  fy_ff    <= 16'd0;
                  x0_ff    <= '0;
                  x1_ff    <= '0;
                  base0_ff <= '0;
                  base1_ff <= '0;
                  if (req_command == CMD_LOAD) begin
                     state_ff <= F_PUSH;
                  end else if (on_grid) begin
                     state_ff <= F_MAP;
                  end
               end
            end
            F_MAP: begin
               fx_ff    <= sb_x[15:0];
               fy_ff    <= sb_y[15:0];
               x0_ff    <= XW'(a_x);
               x1_ff    <= XW'(b_x);
               y0_ff    <= YW'(a_y);
               y1_ff    <= YW'(b_y);
               state_ff <= F_ADDR;
            end
            F_ADDR: begin
               base0_ff <= AW'(y0_ff) * AW'(w_eff);
               base1_ff <= AW'(y1_ff) * AW'(w_eff);
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!job_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/rbi_back.sv @@
// Back part: owns the frame store, performs loads, reads four neighbors and
// interpolates and quantizes each channel. Depends on rbi_pkg.
`default_nettype none
module rbi_back #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18,
   parameter int JOB_W = 78 + 4 * 18
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rbi_pkg::quant_cfg_type qcfg,
   input  wire logic                   job_empty,
   input  wire logic [JOB_W-1:0]       job_data,
   output logic                        job_pop,
   output logic                        res_push,
   input  wire logic                   res_full,
   output rbi_pkg::rsp_type            res_data
);
   import rbi_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_RD, B_LAST, B_MIX1, B_MIX2, B_QUANT, B_OUT}
      back_state_type;

   back_state_type  state_ff;
   logic [23:0]     mem [DEPTH];
   logic [23:0]     rdata_ff;
   logic [AW-1:0]   wp_ff;
   logic [1:0]      cnt_ff;
   logic [1:0]      rd_idx_ff;
   logic            rd_pend_ff;
   logic [AW-1:0]   addr_ff [4];
   logic [23:0]     pix_ff [4];
   logic [9:0]      rx_ff;
   logic [9:0]      ry_ff;
   logic [15:0]     fx_ff;
   logic [15:0]     fy_ff;
   logic [24:0]     top_ff [3];
   logic [24:0]     bot_ff [3];
   logic [25:0]     v16_ff [3];
   logic [17:0]     qi_ff [3];

   logic            j_cmd;
   logic            j_first;
   logic [23:0]     j_pix;
   logic [9:0]      j_rx;
   logic [9:0]      j_ry;
   logic [15:0]     j_fx;
   logic [15:0]     j_fy;
   logic [AW-1:0]   j_a00;
   logic [AW-1:0]   j_a01;
   logic [AW-1:0]   j_a10;
   logic [AW-1:0]   j_a11;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   logic [AW-1:0]   mem_ra;
   logic [16:0]     wx0;
   logic [16:0]     wy0;
   logic [41:0]     v32 [3];
   logic [49:0]     prod [3];
   logic [7:0]      qv [3];

   assign {j_cmd, j_first, j_pix, j_rx, j_ry, j_fx, j_fy, j_a00, j_a01, j_a10, j_a11}
      = job_data;

   assign job_pop = (state_ff == B_IDLE) && !job_empty;
   assign mem_we  = job_pop && (j_cmd == CMD_LOAD);
   assign mem_wa  = j_first ? '0 : wp_ff;
   assign mem_ra  = addr_ff[cnt_ff];
   assign wx0     = 17'd65536 - 17'(fx_ff);
   assign wy0     = 17'd65536 - 17'(fy_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [18:0] q;
         v32[c]  = 42'(top_ff[c]) * 42'(wy0) + 42'(bot_ff[c]) * 42'(fy_ff);
         prod[c] = 50'(v16_ff[c]) * 50'(qcfg.quant_mult) + 50'h0_0000_8000_0000;
         q       = $signed({1'b0, qi_ff[c]}) + 19'(qcfg.zero_point);
         if (q < -19'sd128) begin
            qv[c] = 8'h80;
         end else if (q > 19'sd127) begin
            qv[c] = 8'h7f;
         end else begin
            qv[c] = q[7:0];
         end
      end
   end

   assign res_push       = (state_ff == B_OUT);
   assign res_data.res_x = rx_ff;
   assign res_data.res_y = ry_ff;
   assign res_data.q_r   = qv[0];
   assign res_data.q_g   = qv[1];
   assign res_data.q_b   = qv[2];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= j_pix;
      end
      rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         pix_ff[rd_idx_ff] <= rdata_ff;
      end
      rd_idx_ff <= cnt_ff;
      if (reset) begin
         state_ff   <= B_IDLE;
         wp_ff      <= '0;
         cnt_ff     <= 2'd0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == B_RD);
         case (state_ff)
            B_IDLE: begin
               if (job_pop) begin
                  if (j_cmd == CMD_LOAD) begin
                     wp_ff <= (mem_wa == AW'(DEPTH - 1)) ? '0 : mem_wa + AW'(1);
                  end else begin
                     addr_ff[0] <= j_a00;
                     addr_ff[1] <= j_a01;
                     addr_ff[2] <= j_a10;
                     addr_ff[3] <= j_a11;
                     rx_ff      <= j_rx;
                     ry_ff      <= j_ry;
                     fx_ff      <= j_fx;
                     fy_ff      <= j_fy;
                     cnt_ff     <= 2'd0;
                     state_ff   <= B_RD;
                  end
               end
            end
            B_RD: begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= B_LAST;
               end
            end
            B_LAST: begin
               state_ff <= B_MIX1;
            end
            B_MIX1: begin
               for (int c = 0; c < 3; c++) begin
                  top_ff[c] <= 25'(pix_ff[0][8*c +: 8]) * 25'(wx0)
                             + 25'(pix_ff[1][8*c +: 8]) * 25'(fx_ff);
                  bot_ff[c] <= 25'(pix_ff[2][8*c +: 8]) * 25'(wx0)
                             + 25'(pix_ff[3][8*c +: 8]) * 25'(fx_ff);
               end
               state_ff <= B_MIX2;
            end
            B_MIX2: begin
               for (int c = 0; c < 3; c++) begin
                  v16_ff[c] <= v32[c][41:16] + 26'(v32[c][15]);
               end
               state_ff <= B_QUANT;
            end
            B_QUANT: begin
               for (int c = 0; c < 3; c++) begin
                  qi_ff[c] <= prod[c][49:32];
               end
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (!res_full) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/bilinear_resize_int8_quantize_unit.sv @@
// Top level of the bilinear resize and int8 quantize unit: register file,
// front part, job queue, back part and result queue. Depends on rbi_pkg.
//
//   channel  ports                         handshake
//   request  req_*  (push, full)           push && !full
//   result   rsp_*  (pop, empty)           pop && !empty
//   csr      csr_*  (valid, ready)         valid && ready, ready always high
//
// A load passes the front part and the job queue and is stored when the back part pops
// it; the front part takes the next request once the load is queued. A compute result
// passes the front states for mapping and addressing, then the back states for the four
// one-per-cycle frame store reads, two mixing stages and the quantizing multiply. Reset
// is synchronous and clears control state only; the frame store holds garbage until
// loaded. A full result queue stalls the back part, which then stalls the front part.
`default_nettype none
module bilinear_resize_int8_quantize_unit #(
   parameter int MAX_SRC_WIDTH  = 512,
   parameter int MAX_SRC_HEIGHT = 512,
   parameter int MAX_OUT_SIZE   = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rbi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rbi_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_command,
   input  wire logic                           req_first_pixel,
   input  wire logic [7:0]                     req_pixel_r,
   input  wire logic [7:0]                     req_pixel_g,
   input  wire logic [7:0]                     req_pixel_b,
   input  wire logic [9:0]                     req_out_x,
   input  wire logic [9:0]                     req_out_y,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output logic [9:0]                          rsp_res_x,
   output logic [9:0]                          rsp_res_y,
   output logic signed [7:0]                   rsp_q_r,
   output logic signed [7:0]                   rsp_q_g,
   output logic signed [7:0]                   rsp_q_b
);
   import rbi_pkg::*;

   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int JOB_W = 78 + 4 * AW;

   map_cfg_type      map_cfg_ff;
   quant_cfg_type    quant_cfg_ff;
   logic             job_push;
   logic             job_full;
   logic [JOB_W-1:0] job_wdata;
   logic             job_empty;
   logic [JOB_W-1:0] job_rdata;
   logic             job_pop;
   logic             res_push;
   logic             res_full;
   rsp_type          res_wdata;
   rsp_type          res_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cfg_ff.src_width    <= 10'd512;
         map_cfg_ff.src_height   <= 10'd512;
         map_cfg_ff.out_size     <= 11'd640;
         map_cfg_ff.step_x       <= 26'd65536;
         map_cfg_ff.step_y       <= 26'd65536;
         quant_cfg_ff.quant_mult <= 24'd65536;
         quant_cfg_ff.zero_point <= 8'sd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SRC_WIDTH:  map_cfg_ff.src_width    <= csr_wdata[9:0];
            CSR_SRC_HEIGHT: map_cfg_ff.src_height   <= csr_wdata[9:0];
            CSR_OUT_SIZE:   map_cfg_ff.out_size     <= csr_wdata[10:0];
            CSR_STEP_X:     map_cfg_ff.step_x       <= csr_wdata[25:0];
            CSR_STEP_Y:     map_cfg_ff.step_y       <= csr_wdata[25:0];
            CSR_QUANT_MULT: quant_cfg_ff.quant_mult <= csr_wdata[23:0];
            CSR_ZERO_POINT: quant_cfg_ff.zero_point <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   rbi_front #(
      .MAX_W   (MAX_SRC_WIDTH),
      .MAX_H   (MAX_SRC_HEIGHT),
      .MAX_OUT (MAX_OUT_SIZE),
      .AW      (AW),
      .JOB_W   (JOB_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (map_cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_first_pixel (req_first_pixel),
      .req_pixel_r     (req_pixel_r),
      .req_pixel_g     (req_pixel_g),
      .req_pixel_b     (req_pixel_b),
      .req_out_x       (req_out_x),
      .req_out_y       (req_out_y),
      .job_push        (job_push),
      .job_full        (job_full),
      .job_data        (job_wdata)
   );

   rbi_queue #(.WIDTH(JOB_W)) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .full  (job_full),
      .wdata (job_wdata),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (job_rdata)
   );

   rbi_back #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .JOB_W (JOB_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qcfg      (quant_cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_rdata),
      .job_pop   (job_pop),
      .res_push  (res_push),
      .res_full  (res_full),
      .res_data  (res_wdata)
   );

   rbi_queue #(.WIDTH($bits(rsp_type))) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .wdata (res_wdata),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (res_rdata)
   );

   assign rsp_res_x = res_rdata.res_x;
   assign rsp_res_y = res_rdata.res_y;
   assign rsp_q_r   = res_rdata.q_r;
   assign rsp_q_g   = res_rdata.q_g;
   assign rsp_q_b   = res_rdata.q_b;
endmodule
`default_nettype wire
